// File: rtl/eats_pkg.sv
package eats_pkg;

	localparam int NUM_TASKS_DEF   = 4;
	localparam int NUM_PERIOD_REGS = 4;
	localparam int DATA_W          = 32;
	localparam int REQ_W           = 3;
	localparam int TID_W           = 2;
	localparam int CFG_IDX_W       = 3;

	localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd2;
	localparam logic [REQ_W-1:0] REQ_GET   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SCHED = 3'd4;
	localparam logic [REQ_W-1:0] REQ_START = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_EN    = 3'd0;
	localparam int                   CFG_PERIOD_BASE = 1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} dp_cmd_t;

endpackage

// File: rtl/eats_if.sv
interface eats_req_if;
	logic                            valid;
	logic                            ready;
	logic [eats_pkg::REQ_W-1:0]      req_type;
	logic [eats_pkg::TID_W-1:0]      task_id;
	logic [eats_pkg::DATA_W-1:0]     event_mask;
	logic [eats_pkg::DATA_W-1:0]     offset_ticks;

	modport source (output valid, req_type, task_id, event_mask, offset_ticks, input ready);
	modport sink (input valid, req_type, task_id, event_mask, offset_ticks, output ready);
endinterface

interface eats_res_if;
	logic                        valid;
	logic                        ready;
	logic                        run_valid;
	logic [eats_pkg::TID_W-1:0]  run_task;
	logic                        event_match;

	modport source (output valid, run_valid, run_task, event_match, input ready);
	modport sink (input valid, run_valid, run_task, event_match, output ready);
endinterface

// File: rtl/eats_ctrl.sv
module eats_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output eats_pkg::dp_cmd_t cmd
);

	eats_pkg::ctrl_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= eats_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		// result slot frees when taken, so a new request may enter the same cycle
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			eats_pkg::ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					cmd.capture = 1'b1;
					state_d     = eats_pkg::ST_EXEC;
				end
			end
			eats_pkg::ST_EXEC: begin
				cmd.exec    = 1'b1;
				out_valid_d = 1'b1;
				state_d     = eats_pkg::ST_IDLE;
			end
			default: begin
				state_d = eats_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/eats_dp.sv
module eats_dp #(
	parameter int NUM_TASKS = eats_pkg::NUM_TASKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  eats_pkg::dp_cmd_t                cmd,
	input  logic                             cfg_we,
	input  logic [eats_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [eats_pkg::DATA_W-1:0]      cfg_data,
	input  logic [eats_pkg::REQ_W-1:0]       req_type,
	input  logic [eats_pkg::TID_W-1:0]       task_id,
	input  logic [eats_pkg::DATA_W-1:0]      event_mask,
	input  logic [eats_pkg::DATA_W-1:0]      offset_ticks,
	output logic                             run_valid,
	output logic [eats_pkg::TID_W-1:0]       run_task,
	output logic                             event_match
);

	localparam int NP = eats_pkg::NUM_PERIOD_REGS;
	localparam int DW = eats_pkg::DATA_W;

	// captured request
	logic [eats_pkg::REQ_W-1:0] req_type_q;
	logic [eats_pkg::TID_W-1:0] task_id_q;
	logic [DW-1:0]              event_mask_q;
	logic [DW-1:0]              offset_ticks_q;

	logic [NP-1:0] alarm_en_q;
	logic [DW-1:0] period_q [NP];
	logic [DW-1:0] events_q [NUM_TASKS];
	logic [DW-1:0] timers_q [NUM_TASKS];

	logic                      run_valid_q;
	logic [eats_pkg::TID_W-1:0] run_task_q;
	logic                      event_match_q;

	logic [NUM_TASKS-1:0] alarm_on;
	logic [DW-1:0]        period_of [NUM_TASKS];
	logic [NUM_TASKS-1:0] expired;
	logic [NUM_TASKS-1:0] wake;
	logic [NUM_TASKS-1:0] pick_oh;
	logic                 pick_any;
	logic [eats_pkg::TID_W-1:0] pick_idx;
	logic                 get_hit;

	for (genvar t = 0; t < NUM_TASKS; t++) begin : g_task
		if (t < NP) begin : g_alarm
			assign alarm_on[t]  = alarm_en_q[t];
			assign period_of[t] = period_q[t];
		end else begin : g_no_alarm
			assign alarm_on[t]  = 1'b0;
			assign period_of[t] = '0;
		end
		assign expired[t] = alarm_on[t] && (timers_q[t] == '0);
		assign wake[t]    = (events_q[t] != '0) || expired[t];
	end

	// first waking task in index order
	always_comb begin
		pick_any = 1'b0;
		pick_idx = '0;
		pick_oh  = '0;
		get_hit  = 1'b0;
		for (int t = 0; t < NUM_TASKS; t++) begin
			pick_oh[t] = wake[t] && !pick_any;
			if (pick_oh[t]) begin
				pick_idx = eats_pkg::TID_W'(t);
			end
			pick_any = pick_any || wake[t];
			if (int'(task_id_q) == t && (events_q[t] & event_mask_q) != '0) begin
				get_hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q     <= req_type;
			task_id_q      <= task_id;
			event_mask_q   <= event_mask;
			offset_ticks_q <= offset_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_en_q <= '0;
			for (int p = 0; p < NP; p++) begin
				period_q[p] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_idx == eats_pkg::CFG_ALARM_EN) begin
				alarm_en_q <= cfg_data[NP-1:0];
			end
			for (int p = 0; p < NP; p++) begin
				if (int'(cfg_idx) == eats_pkg::CFG_PERIOD_BASE + p && p < NUM_TASKS) begin
					period_q[p] <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TASKS; t++) begin
				events_q[t] <= '0;
				timers_q[t] <= '0;
			end
		end else if (cmd.exec) begin
			for (int t = 0; t < NUM_TASKS; t++) begin
				case (req_type_q)
					eats_pkg::REQ_TICK: begin
						if (timers_q[t] != '0) begin
							timers_q[t] <= timers_q[t] - 1'b1;
						end
					end
					eats_pkg::REQ_SET: begin
						if (int'(task_id_q) == t) begin
							events_q[t] <= events_q[t] | event_mask_q;
						end
					end
					eats_pkg::REQ_CLEAR: begin
						if (int'(task_id_q) == t) begin
							events_q[t] <= events_q[t] & ~event_mask_q;
						end
					end
					eats_pkg::REQ_SCHED: begin
						if (pick_oh[t] && expired[t]) begin
							timers_q[t] <= period_of[t];
						end
					end
					eats_pkg::REQ_START: begin
						if (int'(task_id_q) == t && alarm_on[t]) begin
							timers_q[t] <= offset_ticks_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			run_valid_q   <= (req_type_q == eats_pkg::REQ_SCHED) && pick_any;
			run_task_q    <= (req_type_q == eats_pkg::REQ_SCHED) ? pick_idx : '0;
			event_match_q <= (req_type_q == eats_pkg::REQ_GET) && get_hit;
		end
	end

	assign run_valid   = run_valid_q;
	assign run_task    = run_task_q;
	assign event_match = event_match_q;

endmodule

// File: rtl/event_alarm_task_scheduler_top.sv
// A request accepted in idle is captured, then executed in the execute state, and its
// result is registered and shown on res. The controller takes no new request while it
// executes one; the input also waits while an untaken result holds the output register.
// Every request settles in the execute state: parallel timer update, priority pick.
// Reset (arst_n low, asynchronous): event words, timers, alarm enables and periods
// clear to zero; no result pending.
module event_alarm_task_scheduler_top #(
	parameter int NUM_TASKS = eats_pkg::NUM_TASKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	eats_req_if.sink                       req,
	eats_res_if.source                     res,
	input  logic                           cfg_we,
	input  logic [eats_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [eats_pkg::DATA_W-1:0]    cfg_data
);

	eats_pkg::dp_cmd_t cmd;

	eats_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd)
	);

	eats_dp #(
		.NUM_TASKS (NUM_TASKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.req_type     (req.req_type),
		.task_id      (req.task_id),
		.event_mask   (req.event_mask),
		.offset_ticks (req.offset_ticks),
		.run_valid    (res.run_valid),
		.run_task     (res.run_task),
		.event_match  (res.event_match)
	);

`ifndef ASSERT_OFF
	// accepted transaction: execute cycle first, result shown the cycle after
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (!res.valid && cmd.exec) ##1 res.valid)
		else $error("result did not follow accepted request");

	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !req.ready)
		else $error("request accepted during execute");

	a_idle_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.run_valid) |-> (res.run_task == '0))
		else $error("run_task set without a picked task");

	a_get_vs_sched: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.run_valid && res.event_match))
		else $error("schedule and get results both set");
`endif

endmodule
